@@ sv/vzd_pkg.sv @@
// shared types and constants for the varint zigzag decoder
package vzd_pkg;

    localparam int unsigned MAX_VARINT_BYTES = 10;
    localparam logic [3:0] LAST_POS = 4'(MAX_VARINT_BYTES - 1);
    localparam logic [3:0] LIMIT_RESET = 4'(MAX_VARINT_BYTES);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVER_LIM  = 3'd1,
        ST_TENTH_OVF = 3'd2,
        ST_OVERLONG  = 3'd3,
        ST_TRUNC     = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       mode;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        logic        emit;
        logic [63:0] value;
        status_t     status;
    } result_t;

endpackage

@@ sv/varint_zigzag_decoder_core.sv @@
// top level: leb128 varint decoder with zigzag mode and apb limit register
// datapath: a byte beat is registered, decoded, and its result registered in the result register that drives m_tvalid
// throughput: one byte beat per cycle, set by the single decode pass between input and result
// registers; the input register stalls only while a result waits in the result register
// reset: synchronous active-low aresetn clears decode state, valid flags and sets the limit to 10
module varint_zigzag_decoder_core
    import vzd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // stream_byte
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // decoded_value
    output logic [2:0]  m_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [63:0] out_value_reg;
    status_t     out_status_reg;

    logic        out_free;
    logic        advance;
    logic [3:0]  limit;
    result_t     res;

    vzd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    vzd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .limit   (limit),
        .res     (res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res.emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && res.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.stream_byte <= s_tdata;
            in_item_reg.mode        <= s_tuser;
            in_item_reg.stream_end  <= s_tlast;
        end
        if (advance && res.emit) begin
            out_value_reg  <= res.value;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

@@ sv/vzd_cfg.sv @@
// apb register block holding the field byte limit
module vzd_cfg
    import vzd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [3:0]  limit
);

    logic [3:0] max_field_bytes_reg;
    logic       sel_reg0;

    assign pready   = 1'b1;
    assign sel_reg0 = (paddr[2] == 1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_field_bytes_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && sel_reg0) begin
            max_field_bytes_reg <= pwdata[3:0];
        end
    end

    assign prdata = sel_reg0 ? {28'd0, max_field_bytes_reg} : 32'd0;

    // values above the varint length behave as the varint length
    assign limit = (max_field_bytes_reg > LIMIT_RESET) ? LIMIT_RESET : max_field_bytes_reg;

endmodule

@@ sv/vzd_decode.sv @@
// decode state and single-pass byte decode logic
module vzd_decode
    import vzd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  item_t      item,
    input  logic [3:0] limit,
    output result_t    res
);

    logic [63:0] acc_reg, acc_next;
    logic [3:0]  pos_reg, pos_next;
    logic        mode_reg, mode_next;

    logic [3:0]  pos_c;
    logic [4:0]  pos_p1;
    logic [4:0]  pos_p2;
    logic [5:0]  shamt;
    logic [63:0] merged;
    logic        eff_mode;

    always_comb begin
        pos_c    = (pos_reg > LAST_POS) ? LAST_POS : pos_reg;
        pos_p1   = 5'(pos_c) + 5'd1;
        pos_p2   = 5'(pos_c) + 5'd2;
        shamt    = 6'(pos_c) * 6'd7;
        merged   = acc_reg | (64'(item.stream_byte[6:0]) << shamt);
        eff_mode = (pos_c == 4'd0) ? item.mode : mode_reg;

        res.emit   = 1'b0;
        res.value  = 64'd0;
        res.status = ST_OK;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        mode_next  = mode_reg;

        if (item.stream_end) begin
            if (pos_c != 4'd0) begin
                res.emit   = 1'b1;
                res.status = ST_TRUNC;
            end
        end else if (pos_p1 > 5'(limit)) begin
            res.emit   = 1'b1;
            res.status = ST_OVER_LIM;
        end else if (pos_c == LAST_POS && item.stream_byte[7:1] != 7'd0) begin
            res.emit   = 1'b1;
            res.status = ST_TENTH_OVF;
        end else if (!item.stream_byte[7]) begin
            res.emit = 1'b1;
            if (pos_c != 4'd0 && item.stream_byte[6:0] == 7'd0) begin
                res.status = ST_OVERLONG;
            end else if (eff_mode) begin
                res.value = (merged >> 1) ^ {64{merged[0]}};
            end else begin
                res.value = merged;
            end
        end else if (pos_p2 > 5'(limit)) begin
            res.emit   = 1'b1;
            res.status = ST_OVER_LIM;
        end else begin
            acc_next  = merged;
            pos_next  = pos_p1[3:0];
            mode_next = eff_mode;
        end

        if (res.emit) begin
            acc_next  = 64'd0;
            pos_next  = 4'd0;
            mode_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= 64'd0;
            pos_reg  <= 4'd0;
            mode_reg <= 1'b0;
        end else if (advance) begin
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
        end
    end

endmodule

@@ tb/varint_zigzag_decoder_core_tb.sv @@
// testbench for varint_zigzag_decoder_core: random and directed byte streams vs a predictor
module varint_zigzag_decoder_core_tb
    import vzd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_MAX_FIELD = 3'd0;
    localparam int         STALL_LIMIT    = 4000;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         SEGMENT_BEATS  = 230;

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } decoded_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    item_t       beat_queue[$];
    decoded_t    expected_results[$];
    int          send_idle_pct = 8;
    int          recv_idle_pct = 86;
    int          mismatches    = 0;
    int          stall_cycles  = 0;

    // predictor state
    logic [63:0] acc_bits    = 64'd0;
    int unsigned acc_pos     = 0;
    logic        acc_zigzag  = 1'b0;
    logic [3:0]  field_limit = LIMIT_RESET;

    varint_zigzag_decoder_core uut (.*);

    always #5 aclk = ~aclk;

    function automatic void post_result(input logic [63:0] value, input status_t status);
        decoded_t r;
        r.value = value;
        r.status = status;
        expected_results.push_back(r);
        acc_bits = 64'd0;
        acc_pos = 0;
        acc_zigzag = 1'b0;
    endfunction

    function automatic void decode_byte(input item_t it);
        int unsigned lim;
        int unsigned pos;
        logic [63:0] v;
        lim = (field_limit > LIMIT_RESET) ? MAX_VARINT_BYTES : int'(field_limit);
        pos = (acc_pos > LAST_POS) ? int'(LAST_POS) : acc_pos;
        if (it.stream_end) begin
            if (pos != 0)
                post_result(64'd0, ST_TRUNC);
            return;
        end
        if (pos + 1 > lim) begin
            post_result(64'd0, ST_OVER_LIM);
            return;
        end
        if (pos == 0)
            acc_zigzag = it.mode;
        if (pos == LAST_POS && it.stream_byte[7:1] != 7'd0) begin
            post_result(64'd0, ST_TENTH_OVF);
            return;
        end
        acc_bits = acc_bits | (64'(it.stream_byte[6:0]) << (pos * 7));
        if (!it.stream_byte[7]) begin
            v = acc_bits;
            if (pos != 0 && it.stream_byte[6:0] == 7'd0) begin
                post_result(64'd0, ST_OVERLONG);
            end else begin
                if (acc_zigzag)
                    v = (v >> 1) ^ {64{v[0]}};
                post_result(v, ST_OK);
            end
            return;
        end
        if (pos + 2 > lim)
            post_result(64'd0, ST_OVER_LIM);
        else
            acc_pos = pos + 1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("error at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // driver
    always @(posedge aclk) begin
        item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                decode_byte('{stream_byte: s_tdata, mode: s_tuser, stream_end: s_tlast});
            if (!s_tvalid || s_tready) begin
                if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = beat_queue.pop_front();
                    s_tdata  <= it.stream_byte;
                    s_tuser  <= it.mode;
                    s_tlast  <= it.stream_end;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        decoded_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %h/%0d with nothing pending",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch($sformatf("value %h, want %h", m_tdata, want.value));
                    if (m_tuser !== 3'(want.status))
                        report_mismatch($sformatf("status %0d, want %s", m_tuser,
                                                  want.status.name()));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("varint_zigzag_decoder_core: mismatch");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic m);
        item_t it;
        it.stream_byte = b;
        it.mode = m;
        it.stream_end = 1'b0;
        beat_queue.push_back(it);
    endtask

    task automatic queue_end();
        item_t it;
        it.stream_byte = 8'($urandom);
        it.mode = 1'($urandom);
        it.stream_end = 1'b1;
        beat_queue.push_back(it);
    endtask

    // pad > 0 appends that many redundant groups, ending in a zero byte
    task automatic queue_varint(input logic [63:0] u, input logic zz, input int pad);
        logic [63:0] rest;
        logic        first;
        logic        cont;
        first = 1'b1;
        rest = u;
        do begin
            cont = ((rest >> 7) != 64'd0) || (pad != 0);
            queue_byte({cont, rest[6:0]}, first ? zz : 1'($urandom));
            rest = rest >> 7;
            first = 1'b0;
        end while (rest != 64'd0);
        for (int i = 0; i < pad; i++)
            queue_byte({i != pad - 1, 7'h00}, 1'($urandom));
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          bits;
        v = {$urandom, $urandom};
        bits = $urandom_range(64, 0);
        if (bits < 64)
            v = v & ((64'd1 << bits) - 64'd1);
        return v;
    endfunction

    task automatic queue_random_run();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 70) begin
            queue_varint(random_value(), 1'($urandom), 0);
        end else if (r < 78) begin
            queue_varint(random_value(), 1'($urandom), $urandom_range(3, 1));
        end else if (r < 85) begin
            n = $urandom_range(9, 1);
            repeat (n) queue_byte({1'b1, 7'($urandom)}, 1'($urandom));
            queue_end();
        end else if (r < 90) begin
            repeat (9) queue_byte({1'b1, 7'($urandom)}, 1'($urandom));
            queue_byte(8'($urandom), 1'($urandom));
        end else if (r < 95) begin
            queue_byte(8'($urandom), 1'($urandom));
        end else begin
            queue_end();
        end
    endtask

    task automatic wait_drained();
        while (beat_queue.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_max_field(input logic [3:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_FIELD;
        pwdata  <= 32'(v);
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        field_limit = v;
        @(negedge aclk);
    endtask

    initial begin
        logic [3:0] limits[6];
        limits = '{4'd0, 4'd15, 4'd1, 4'($urandom_range(9, 2)), 4'd10,
                   4'($urandom_range(15, 0))};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset limit
        queue_varint(64'd0, 1'b0, 0);
        queue_varint({64{1'b1}}, 1'b0, 0);
        queue_varint(64'd1, 1'b1, 0);
        queue_varint({64{1'b1}}, 1'b1, 0);
        queue_varint(64'd0, 1'b0, 1);
        repeat (9) queue_byte(8'hff, 1'b0);
        queue_byte(8'h02, 1'b1);
        queue_end();
        queue_byte(8'h80, 1'b1);
        queue_end();

        for (int seg = 0; seg < 6; seg++) begin
            write_max_field(limits[seg]);
            send_idle_pct = (seg < 2) ? 8 : (seg < 4) ? 86 : 0;
            recv_idle_pct = (seg < 2) ? 86 : (seg < 4) ? 8 : 0;
            while (beat_queue.size() < SEGMENT_BEATS / 2)
                queue_random_run();
            if (seg == 2)
                wait_drained();
            while (beat_queue.size() < ((seg == 2) ? SEGMENT_BEATS / 2 : SEGMENT_BEATS))
                queue_random_run();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("varint_zigzag_decoder_core: match");
        else
            $display("varint_zigzag_decoder_core: mismatch");
        $finish;
    end

endmodule
